// ===== hdl/fkrc_pkg.sv =====
`timescale 1ns / 1ps

package fkrc_pkg;

    // Byte codes seen by the parser
    localparam logic [7:0] CH_UPPER_N = 8'h4E;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_HEADER  = 8'h3E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    localparam int OUT_W  = 40;   // width of each count on the result channel
    localparam int PEND_W = 32;   // held-back whitespace counter

    localparam int          APB_AW          = 3;
    localparam logic [0:0]  REG_KMER_LENGTH = 1'b0;   // register index, paddr[2]
    localparam logic [7:0]  KMER_LEN_RESET  = 8'd31;

    typedef enum logic [2:0] {
        LM_START = 3'b001,
        LM_SEQ   = 3'b010,
        LM_HDR   = 3'b100
    } t_line_mode;

    // Event flags passed down the count pipeline
    typedef struct packed {
        logic close;      // a run ends; its length travels alongside
        logic emit_rec;   // report the open record
        logic emit_err;   // report malformed input
    } t_evt;

endpackage

// ===== hdl/fasta_kmer_run_counter.sv =====
`timescale 1ns / 1ps

// Channel    Dir  Payload                                   Handshake
// s_axis     in   tdata = ch[7:0], tuser = end_of_stream     tvalid/tready
// m_axis     out  tdata = kmer_count, base_count; tuser=kind tvalid/tready
// apb        in   reg 0 at 0x0: kmer_length[7:0]             psel/penable, pready=1
//
// One byte per cycle unless the input stalls (see below). A result reaches the output
// register through the parse stage, k-mer contribution stage and accumulate stage.
// Input stalls only while a finished result waits at the output and another one
// has reached the accumulate stage. Reset is synchronous, active low, and returns
// kmer_length to 31.
module fasta_kmer_run_counter
    import fkrc_pkg::*;
#(
    parameter int COUNT_WIDTH = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,    // [7:0] ch
    input  logic                 s_axis_tuser,    // [0] end_of_stream
    // master stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*OUT_W-1:0]   m_axis_tdata,    // [39:0] kmer_count, [79:40] base_count
    output logic                 m_axis_tuser,    // [0] kind
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int W = COUNT_WIDTH;
    localparam logic [W-1:0] CNT_MAX = '1;

    // ---------------- configuration ----------------
    logic [7:0] r_kmer_len;
    logic [7:0] r_km1;         // k - 1, with k = 0 treated as 1
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_KMER_LENGTH);
    assign prdata = (paddr[2] == REG_KMER_LENGTH) ? {24'd0, r_kmer_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= KMER_LEN_RESET;
            r_km1      <= KMER_LEN_RESET - 8'd1;
        end else if (cfg_wr) begin
            r_kmer_len <= pwdata[7:0];
            r_km1      <= (pwdata[7:0] == 8'd0) ? 8'd0 : pwdata[7:0] - 8'd1;
        end
    end

    // ---------------- handshake ----------------
    t_evt r_e1, r_e2;
    logic r_out_valid;
    logic stall, adv, accept;

    assign stall         = (r_e2.emit_rec || r_e2.emit_err) && r_out_valid && !m_axis_tready;
    assign adv           = !stall;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // ---------------- parse stage ----------------
    t_line_mode           r_line_mode, n_line_mode;
    logic                 r_record_open, n_record_open;
    logic                 r_header_named, n_header_named;
    logic                 r_halted, n_halted;
    logic [W-1:0]         r_run, n_run;
    logic [PEND_W-1:0]    r_pend, n_pend;
    logic [W-1:0]         r_base, n_base;
    logic [W-1:0]         r_e1_len, n_e1_len;
    logic [W-1:0]         r_e1_base, n_e1_base;
    t_evt                 n_e1;

    logic [7:0]           b;
    logic                 eos, is_ws, is_n;
    logic [PEND_W-1:0]    pend_eff;
    logic [W:0]           run_sum, base_sum;
    logic [W-1:0]         run_sat, base_sat;

    assign b     = s_axis_tdata;
    assign eos   = s_axis_tuser;
    assign is_ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
    assign is_n  = (b == CH_UPPER_N) || (b == CH_LOWER_N);

    // Held-back whitespace joins the run together with the current byte
    assign pend_eff = (r_line_mode == LM_SEQ) ? r_pend : '0;
    assign run_sum  = {1'b0, r_run} + (W+1)'(pend_eff) + (W+1)'(!is_n);
    assign base_sum = {1'b0, r_base} + (W+1)'(pend_eff) + (W+1)'(1'b1);
    assign run_sat  = run_sum[W]  ? CNT_MAX : run_sum[W-1:0];
    assign base_sat = base_sum[W] ? CNT_MAX : base_sum[W-1:0];

    always_comb begin
        n_line_mode    = r_line_mode;
        n_record_open  = r_record_open;
        n_header_named = r_header_named;
        n_halted       = r_halted;
        n_run          = r_run;
        n_pend         = r_pend;
        n_base         = r_base;
        n_e1           = '0;
        n_e1_len       = r_run;
        n_e1_base      = r_base;

        if (r_halted) begin
            // drop everything until reset
        end else if (eos) begin
            if (r_line_mode == LM_HDR && !r_header_named) begin
                n_e1.emit_err = 1'b1;
                n_halted      = 1'b1;
            end else begin
                if (r_record_open) begin
                    n_e1.close    = 1'b1;
                    n_e1.emit_rec = 1'b1;
                end
                n_line_mode    = LM_START;
                n_record_open  = 1'b0;
                n_header_named = 1'b0;
                n_run          = '0;
                n_pend         = '0;
                n_base         = '0;
            end
        end else begin
            case (r_line_mode)
                LM_SEQ: begin
                    if (b == CH_LF) begin
                        n_pend      = '0;
                        n_line_mode = LM_START;
                    end else if (is_ws) begin
                        if (r_pend != '1) n_pend = r_pend + 1'b1;
                    end else begin
                        n_pend = '0;
                        n_base = base_sat;
                        if (is_n) begin
                            n_e1.close = 1'b1;
                            n_e1_len   = run_sat;
                            n_run      = '0;
                        end else begin
                            n_run = run_sat;
                        end
                    end
                end
                LM_HDR: begin
                    if (b == CH_LF) begin
                        n_line_mode = LM_START;
                        if (!r_header_named) begin
                            n_e1.emit_err = 1'b1;
                            n_halted      = 1'b1;
                        end
                    end else if (!is_ws) begin
                        n_header_named = 1'b1;
                    end
                end
                LM_START: begin
                    if (b == CH_LF || is_ws) begin
                        // skip leading whitespace and blank lines
                    end else if (b == CH_HEADER) begin
                        if (r_record_open) begin
                            n_e1.close    = 1'b1;
                            n_e1.emit_rec = 1'b1;
                        end
                        n_record_open  = 1'b1;
                        n_header_named = 1'b0;
                        n_run          = '0;
                        n_pend         = '0;
                        n_base         = '0;
                        n_line_mode    = LM_HDR;
                    end else if (!r_record_open) begin
                        n_e1.emit_err = 1'b1;
                        n_halted      = 1'b1;
                    end else begin
                        n_line_mode = LM_SEQ;
                        n_pend      = '0;
                        n_base      = base_sat;
                        if (is_n) begin
                            n_e1.close = 1'b1;
                            n_e1_len   = run_sat;
                            n_run      = '0;
                        end else begin
                            n_run = run_sat;
                        end
                    end
                end
                default: begin
                    n_line_mode = LM_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode    <= LM_START;
            r_record_open  <= 1'b0;
            r_header_named <= 1'b0;
            r_halted       <= 1'b0;
            r_run          <= '0;
            r_pend         <= '0;
            r_base         <= '0;
            r_e1           <= '0;
        end else if (adv) begin
            r_e1 <= accept ? n_e1 : '0;
            if (accept) begin
                r_line_mode    <= n_line_mode;
                r_record_open  <= n_record_open;
                r_header_named <= n_header_named;
                r_halted       <= n_halted;
                r_run          <= n_run;
                r_pend         <= n_pend;
                r_base         <= n_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && accept) begin
            r_e1_len  <= n_e1_len;
            r_e1_base <= n_e1_base;
        end
    end

    // ---------------- contribution stage: L - k + 1 when L >= k ----------------
    logic [W-1:0] r_e2_add, n_e2_add;
    logic [W-1:0] r_e2_base;

    assign n_e2_add = (r_e1_len > W'(r_km1)) ? r_e1_len - W'(r_km1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2 <= '0;
        end else if (adv) begin
            r_e2 <= r_e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e2_add  <= n_e2_add;
            r_e2_base <= r_e1_base;
        end
    end

    // ---------------- accumulate stage and result register ----------------
    logic [W-1:0]       r_kmer_total;
    logic [W:0]         kmer_sum;
    logic [W-1:0]       kmer_after;
    logic [63:0]        kmer_ext, base_ext;
    logic               r_out_kind;
    logic [OUT_W-1:0]   r_out_kmer, r_out_base;

    assign kmer_sum   = {1'b0, r_kmer_total} + {1'b0, r_e2_add};
    assign kmer_after = r_e2.close ? (kmer_sum[W] ? CNT_MAX : kmer_sum[W-1:0]) : r_kmer_total;
    assign kmer_ext   = 64'(kmer_after);
    assign base_ext   = 64'(r_e2_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;
            if (adv) begin
                if (r_e2.emit_rec) begin
                    r_kmer_total <= '0;
                    r_out_valid  <= 1'b1;
                end else begin
                    r_kmer_total <= kmer_after;
                    if (r_e2.emit_err) r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && (r_e2.emit_rec || r_e2.emit_err)) begin
            r_out_kind <= r_e2.emit_err;
            r_out_kmer <= r_e2.emit_err ? '0 : kmer_ext[OUT_W-1:0];
            r_out_base <= r_e2.emit_err ? '0 : base_ext[OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {r_out_base, r_out_kmer};

    // ---------------- assertions ----------------
    a_err_zero_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero counts");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_halted) |=> !(r_e1.emit_rec || r_e1.emit_err))
        else $error("result raised after halt");

    a_one_event_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_e1.emit_rec && r_e1.emit_err))
        else $error("record and error raised by one byte");

    a_blocked_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e2.emit_rec && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result path blocked");

endmodule

// ===== tb/fasta_kmer_run_counter_checker.sv =====
`timescale 1ns / 1ps

module fasta_kmer_run_counter_checker
    import fkrc_pkg::*;
#(
    parameter int COUNT_WIDTH = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [7:0]           i_s_tdata,     // [7:0] ch
    input  logic                 i_s_tuser,     // [0] end_of_stream
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [2*OUT_W-1:0]   i_m_tdata,     // [39:0] kmer_count, [79:40] base_count
    input  logic                 i_m_tuser,     // [0] kind
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [APB_AW-1:0]    i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic [31:0]          i_prdata,
    input  logic                 i_pready,
    output int                   o_outstanding,
    output int                   o_errors,
    output int                   o_checked
);

    typedef struct packed {
        logic             kind;
        logic [OUT_W-1:0] kmers;
        logic [OUT_W-1:0] bases;
    } t_record_report;

    localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - COUNT_WIDTH);

    t_record_report record_reports_q[$];
    int             mismatches   = 0;
    int             results_seen = 0;

    // parser image
    t_line_mode  mode;
    logic        rec_open;
    logic        hdr_named;
    logic        halted;
    logic [63:0] run_len;
    logic [31:0] ws_held;
    logic [63:0] kmer_tot;
    logic [63:0] base_tot;
    logic [7:0]  k_len;

    assign o_errors  = mismatches;
    assign o_checked = results_seen;

    function automatic logic [63:0] count_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (s < a || s > COUNT_MAX)
            return COUNT_MAX;
        return s;
    endfunction

    task flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task end_clean_run();
        logic [63:0] k;
        k = (k_len == 8'd0) ? 64'd1 : {56'd0, k_len};
        if (run_len >= k)
            kmer_tot = count_add(kmer_tot, run_len - k + 64'd1);
        run_len = '0;
    endtask

    task add_base(input logic [7:0] b);
        base_tot = count_add(base_tot, 64'd1);
        if (b == CH_UPPER_N || b == CH_LOWER_N)
            end_clean_run();
        else
            run_len = count_add(run_len, 64'd1);
    endtask

    task commit_held_space();
        run_len  = count_add(run_len, {32'd0, ws_held});
        base_tot = count_add(base_tot, {32'd0, ws_held});
        ws_held  = '0;
    endtask

    task push_record();
        t_record_report r;
        end_clean_run();
        r.kind  = 1'b0;
        r.kmers = kmer_tot[OUT_W-1:0];
        r.bases = base_tot[OUT_W-1:0];
        record_reports_q.push_back(r);
        kmer_tot = '0;
        base_tot = '0;
    endtask

    task push_error();
        t_record_report r;
        halted  = 1'b1;
        r.kind  = 1'b1;
        r.kmers = '0;
        r.bases = '0;
        record_reports_q.push_back(r);
    endtask

    task clear_parse();
        mode      = LM_START;
        rec_open  = 1'b0;
        hdr_named = 1'b0;
        run_len   = '0;
        ws_held   = '0;
        kmer_tot  = '0;
        base_tot  = '0;
    endtask

    task parse_fasta_byte(input logic [7:0] b, input logic eos);
        logic ws;
        ws = (b == CH_SPACE || b == CH_TAB || b == CH_CR);
        if (halted)
            return;
        if (eos) begin
            if (mode == LM_HDR && !hdr_named) begin
                push_error();
                return;
            end
            if (rec_open)
                push_record();
            clear_parse();
            return;
        end
        case (mode)
            LM_SEQ: begin
                if (b == CH_LF) begin
                    ws_held = '0;
                    mode    = LM_START;
                end else if (ws) begin
                    if (ws_held != '1)
                        ws_held++;
                end else begin
                    commit_held_space();
                    add_base(b);
                end
            end
            LM_HDR: begin
                if (b == CH_LF) begin
                    mode = LM_START;
                    if (!hdr_named)
                        push_error();
                end else if (!ws) begin
                    hdr_named = 1'b1;
                end
            end
            default: begin
                mode = LM_START;
                if (b != CH_LF && !ws) begin
                    if (b == CH_HEADER) begin
                        // previous record closes on the '>' of the next header
                        if (rec_open)
                            push_record();
                        rec_open  = 1'b1;
                        hdr_named = 1'b0;
                        run_len   = '0;
                        ws_held   = '0;
                        kmer_tot  = '0;
                        base_tot  = '0;
                        mode      = LM_HDR;
                    end else if (!rec_open) begin
                        push_error();
                    end else begin
                        mode    = LM_SEQ;
                        ws_held = '0;
                        add_base(b);
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_record_report got;
        t_record_report want;
        if (!i_rst_n) begin
            clear_parse();
            halted = 1'b0;
            k_len  = KMER_LEN_RESET;
            record_reports_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_KMER_LENGTH)
                        k_len = i_pwdata[7:0];
                end else if (i_prdata !== {24'd0, k_len}) begin
                    flag_mismatch("kmer_length readback", 64'(i_prdata), 64'(k_len));
                end
            end
            // compare output first so a stray result is never matched to a fresh expectation
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                got.kind  = i_m_tuser;
                got.kmers = i_m_tdata[OUT_W-1:0];
                got.bases = i_m_tdata[2*OUT_W-1:OUT_W];
                if (record_reports_q.size() == 0) begin
                    flag_mismatch("result with nothing expected, kind", 64'(got.kind), 64'd0);
                end else begin
                    want = record_reports_q.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch("kind", 64'(got.kind), 64'(want.kind));
                    if (got.kmers !== want.kmers)
                        flag_mismatch("kmer_count", 64'(got.kmers), 64'(want.kmers));
                    if (got.bases !== want.bases)
                        flag_mismatch("base_count", 64'(got.bases), 64'(want.bases));
                end
            end
            if (i_s_tvalid && i_s_tready)
                parse_fasta_byte(i_s_tdata, i_s_tuser);
            o_outstanding <= record_reports_q.size();
        end
    end

endmodule

// ===== tb/tb_fasta_kmer_run_counter.sv =====
`timescale 1ns / 1ps

module tb_fasta_kmer_run_counter;
    import fkrc_pkg::*;

    localparam int                COUNT_WIDTH  = 40;
    localparam int                STALL_LIMIT  = 3000;
    localparam int                DRAIN_CYCLES = 8;
    localparam logic [APB_AW-1:0] KLEN_ADDR    = {REG_KMER_LENGTH, 2'b00};

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               s_axis_tuser  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [2*OUT_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [APB_AW-1:0]  paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    int outstanding;
    int mismatches;
    int checked;
    int src_idle      = 0;
    int dst_idle      = 0;
    int bytes_sent    = 0;
    int settings_used = 0;
    int stall_cycles  = 0;
    int end_kind      = 0;

    fasta_kmer_run_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fasta_kmer_run_counter_checker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_outstanding (outstanding),
        .o_errors      (mismatches),
        .o_checked     (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= dst_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("fasta_kmer_run_counter test failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // hold the sender until every record is out, then let the pipeline empty
    task automatic drain_and_hold();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= KLEN_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_kmer_length(input logic [7:0] k);
        logic [31:0] w;
        drain_and_hold();
        w      = $urandom;
        w[7:0] = k;
        apb_xfer(1'b1, w);
        apb_xfer(1'b0, '0);
        settings_used++;
    endtask

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] pick_base(input int n_pct);
        string alphabet;
        alphabet = "ACGTacgt";
        if ($urandom_range(0, 99) < n_pct)
            return $urandom_range(0, 1) ? CH_UPPER_N : CH_LOWER_N;
        return alphabet[$urandom_range(0, 7)];
    endfunction

    // mostly bases, with inner whitespace and raw noise bytes mixed in
    function automatic logic [7:0] pick_seq_byte(input int n_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return pick_ws();
        if (r < 8)
            return any_but_lf();
        return pick_base(n_pct);
    endfunction

    task automatic send_ws(input int max_n);
        int n;
        n = $urandom_range(0, max_n);
        repeat (n) send_byte(pick_ws(), 1'b0);
    endtask

    task automatic send_header(input logic close_line);
        logic [7:0] b;
        send_ws(2);
        send_byte(CH_HEADER, 1'b0);
        send_ws(1);
        do
            b = any_but_lf();
        while (is_ws(b));
        send_byte(b, 1'b0);
        repeat ($urandom_range(0, 8)) send_byte(any_but_lf(), 1'b0);
        send_ws(2);
        if (close_line)
            send_byte(CH_LF, 1'b0);
    endtask

    task automatic send_seq_line(input int n_pct, input int len, input logic close_line);
        send_ws(2);
        send_byte(pick_base(n_pct), 1'b0);
        repeat (len - 1) send_byte(pick_seq_byte(n_pct), 1'b0);
        send_ws(3);
        if (close_line)
            send_byte(CH_LF, 1'b0);
    endtask

    task automatic send_file(input logic [7:0] k);
        int   n_recs;
        int   n_lines;
        int   n_pct;
        int   max_len;
        logic long_rec;
        logic is_last;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                send_ws(3);
                send_byte(CH_LF, 1'b0);
            end
        end
        n_recs = $urandom_range(1, 4);
        for (int r = 0; r < n_recs; r++) begin
            case ($urandom_range(0, 5))
                0, 1:    n_pct = 0;
                2:       n_pct = 1;
                3:       n_pct = 5;
                4:       n_pct = 20;
                default: n_pct = 50;
            endcase
            // long runs give large k something to count
            long_rec = ($urandom_range(0, 5) == 0) || (k >= 8'd100 && $urandom_range(0, 1));
            max_len  = long_rec ? 80 : 16;
            n_lines  = long_rec ? $urandom_range(3, 6) : $urandom_range(0, 3);
            is_last  = (r == n_recs - 1);
            send_header(!(is_last && n_lines == 0 && $urandom_range(0, 3) == 0));
            for (int l = 0; l < n_lines; l++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_ws(2);
                    send_byte(CH_LF, 1'b0);
                end
                send_seq_line(n_pct, $urandom_range(1, max_len),
                              !(is_last && l == n_lines - 1 && $urandom_range(0, 2) == 0));
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 5) == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin : stimulus
        logic [7:0] k_plan [6];
        int         target;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle = 32;
        dst_idle = 74;

        // reset value of kmer_length, then a record using it
        apb_xfer(1'b0, '0);
        send_text(" >");
        send_byte(8'h00, 1'b0);
        send_byte(CH_CR, 1'b0);
        send_text("\n\tA");
        send_byte(8'hFF, 1'b0);
        send_text("N G\t");
        send_byte(CH_CR, 1'b0);
        send_text("\n");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);

        // zero k acts as one; flush on the next '>'; trailing blanks dropped at end of file
        set_kmer_length(8'd0);
        send_text(">q\nNnAC\n>r\nA \t");
        send_byte(8'h00, 1'b1);

        k_plan = '{8'd1, 8'd255, 8'($urandom_range(2, 8)), 8'($urandom_range(9, 40)),
                   8'($urandom_range(1, 255)), 8'd2};
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle = 32;
                    dst_idle = 74;
                end
                1: begin
                    src_idle = 74;
                    dst_idle = 32;
                end
                default: begin
                    src_idle = 0;
                    dst_idle = 0;
                end
            endcase
            for (int s = 0; s < 2; s++) begin
                set_kmer_length(k_plan[phase * 2 + s]);
                target = bytes_sent + 220;
                while (bytes_sent < target)
                    send_file(k_plan[phase * 2 + s]);
            end
        end

        // finish on malformed input; everything after it must be dropped
        end_kind = $urandom_range(0, 1);
        if (end_kind == 0) begin
            send_text(">ok\nACGTTGCA\n>");
            send_byte(CH_SPACE, 1'b0);
            send_byte(CH_CR, 1'b0);
            if ($urandom_range(0, 1))
                send_byte(CH_LF, 1'b0);
            else
                send_byte(8'h00, 1'b1);
        end else begin
            send_byte(8'h00, 1'b1);
            send_text(" \tAC\n");
        end
        send_text(">late\nACGT\n");
        send_byte(8'hFF, 1'b1);

        drain_and_hold();
        repeat (16) @(posedge i_clk);

        $display("Ran %0d stream bytes over %0d kmer_length settings (0, 1 and 255 included)",
                 bytes_sent, settings_used);
        $display("under three stall mixes; %0d results compared, ending on a %s.", checked,
                 end_kind ? "sequence line with no header" : "header with no name");
        if (mismatches == 0 && outstanding == 0)
            $display("fasta_kmer_run_counter test passed");
        else
            $display("fasta_kmer_run_counter test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fkrc_pkg.sv
hdl/fasta_kmer_run_counter.sv
tb/fasta_kmer_run_counter_checker.sv
tb/tb_fasta_kmer_run_counter.sv
